// File: design/ffha_pkg.sv
package ffha_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int MAX_SEGMENTS = 64;
  localparam int HDR_BYTES    = 64;
  localparam int ALIGN_BYTES  = 16;
  localparam int MIN_LEFTOVER = 16;
  localparam int NULL_LIMIT   = 1000;

  localparam int ADDR_W = 48;
  localparam int LEN_W  = 17;
  localparam int SIZE_W = LEN_W + 1;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int OFF_W  = $clog2(HEAP_BYTES + HDR_BYTES + 1);
  localparam int ALU_W  = SIZE_W;
  localparam int STAT_W = 3;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_FIT       = 3'd1,
    ST_NULL_ADDR    = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_INVALID      = 3'd4
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_EV,
    S_SH_CHK,
    S_SH_WR,
    S_SPL_HI,
    S_SPL_LO,
    S_MN_CHK,
    S_MN_EV,
    S_MP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             is_free;
    logic [LEN_W-1:0] len;
  } seg_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    seg_entry_t       data;
  } mem_wr_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [LEN_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_address;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_address;
    status_e           status;
    logic [CNT_W-1:0]  used_count;
    logic [LEN_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  segment_count;
  } result_t;

endpackage

// File: design/first_fit_heap_allocator_top.sv
// Each request walks the segment table, a read and an evaluate state per segment visited,
//   then a check and a write state per table entry moved when a split opens a slot or a
//   merge closes one. Requests are taken one at a time, paced by the segment table, which
//   has one read and one write port, and by the shared header adder.
// Reset (rst, synchronous): the init state writes the initial free segment, then ready.
//   heap_base clears to 0.
module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst,
  // configuration: heap_base
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [16:0] req_size, [64:17] free_address, zero pad
  input  logic        s_axis_tuser,  // cmd: 0 allocate, 1 free
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // [47:0] alloc_address, [50:48] status,
                                     // [57:51] used_count, [74:58] used_bytes,
                                     // [81:75] segment_count, zero pad
);
  import ffha_pkg::*;

  logic [ADDR_W-1:0] heap_base;
  item_t             req;
  result_t           res, out_q;
  logic              res_valid, res_ready, out_valid;

  // Configuration is always taken; the base only shifts addresses, the table stays.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (cfg_valid) begin
      heap_base <= cfg_data;
    end
  end

  // Unpack the request transfer.
  assign req.cmd          = cmd_e'(s_axis_tuser);
  assign req.req_size     = s_axis_tdata[16:0];
  assign req.free_address = s_axis_tdata[64:17];

  ffha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .heap_base (heap_base),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: hold a finished result until the downstream transfer, so the
  // core can return to idle and take the next request meanwhile.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_q.segment_count, out_q.used_bytes, out_q.used_count,
                          out_q.status, out_q.alloc_address};

endmodule

// File: design/ffha_mem.sv
module ffha_mem (
  input  logic                           clk,
  input  ffha_pkg::mem_wr_t              wr,
  input  logic [ffha_pkg::IDX_W-1:0]     rd_addr,
  output ffha_pkg::seg_entry_t           rd_data
);
  import ffha_pkg::*;

  seg_entry_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/ffha_alu.sv
module ffha_alu (
  input  ffha_pkg::alu_op_e            op,
  input  logic [ffha_pkg::ALU_W-1:0]   a,
  input  logic [ffha_pkg::ALU_W-1:0]   b,
  output logic [ffha_pkg::ALU_W-1:0]   y
);
  import ffha_pkg::*;

  // a + b + header, or a - b - header
  always_comb begin
    case (op)
      ALU_ADD: y = a + b + ALU_W'(HDR_BYTES);
      ALU_SUB: y = a - b - ALU_W'(HDR_BYTES);
      default: y = a + b + ALU_W'(HDR_BYTES);
    endcase
  end

endmodule

// File: design/ffha_core.sv
module ffha_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ffha_pkg::ADDR_W-1:0]   heap_base,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  ffha_pkg::item_t               req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ffha_pkg::result_t             res
);
  import ffha_pkg::*;

  state_e            state, state_next, ret_state;
  logic [CNT_W-1:0]  idx, j, live, alloc_cnt;
  logic [LEN_W-1:0]  alloc_bytes, cur_len, prev_len;
  logic              prev_free, sh_up;
  logic [OFF_W-1:0]  off_hdr;
  cmd_e              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W:0]   thr_q;
  logic [ADDR_W-1:0] faddr_q, res_addr;
  status_e           res_status;

  mem_wr_t           wr;
  logic [IDX_W-1:0]  rd_addr;
  seg_entry_t        ent;
  alu_op_e           alu_op;
  logic [ALU_W-1:0]  alu_a, alu_b, alu_y;

  logic [CNT_W-1:0]  idx_inc, idx_dec, j_inc, j_dec;
  logic [ADDR_W-1:0] abs_addr;
  logic              walk_end, addr_match, fits_split, fits_exact, room, sh_more;
  logic [SIZE_W-1:0] size0, size_rnd;

  ffha_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (ent)
  );

  ffha_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign idx_inc    = idx + 1'b1;
  assign idx_dec    = idx - 1'b1;
  assign j_inc      = j + 1'b1;
  assign j_dec      = j - 1'b1;
  assign abs_addr   = heap_base + ADDR_W'(off_hdr);
  assign walk_end   = idx_inc >= live;
  assign addr_match = abs_addr == faddr_q;
  assign fits_split = ent.is_free && ((SIZE_W + 1)'(ent.len) > thr_q);
  assign fits_exact = ent.is_free && (SIZE_W'(ent.len) == size_q);
  assign room       = live < CNT_W'(MAX_SEGMENTS);
  assign sh_more    = sh_up ? (j > idx_inc) : (j < live);

  // round the request up to the alignment, zero counts as one unit
  assign size0    = (req.req_size == '0) ? SIZE_W'(ALIGN_BYTES) : SIZE_W'(req.req_size);
  assign size_rnd = (size0 + SIZE_W'(ALIGN_BYTES - 1)) & ~SIZE_W'(ALIGN_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    rd_addr    = '0;
    alu_op     = ALU_ADD;
    alu_a      = ALU_W'(off_hdr);
    alu_b      = ALU_W'(ent.len);
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    case (state)
      S_INIT: begin
        wr.en   = 1'b1;
        wr.addr = '0;
        wr.data = '{is_free: 1'b1, len: LEN_W'(HEAP_BYTES - HDR_BYTES)};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.cmd == CMD_FREE && req.free_address < ADDR_W'(NULL_LIMIT)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        rd_addr    = idx[IDX_W-1:0];
        state_next = S_EV;
      end
      S_EV: begin
        if (cmd_q == CMD_ALLOC) begin
          if (fits_split && room) begin
            state_next = S_SH_CHK;
          end else if (fits_exact) begin
            wr.en   = 1'b1;
            wr.addr = idx[IDX_W-1:0];
            wr.data = '{is_free: 1'b0, len: ent.len};
            state_next = S_DONE;
          end else if (walk_end) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end else begin
          if (addr_match) begin
            state_next = ent.is_free ? S_DONE : S_MN_CHK;
          end else if (walk_end) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_SH_CHK: begin
        if (sh_more) begin
          rd_addr    = sh_up ? j_dec[IDX_W-1:0] : j_inc[IDX_W-1:0];
          state_next = S_SH_WR;
        end else begin
          state_next = ret_state;
        end
      end
      S_SH_WR: begin
        wr.en      = 1'b1;
        wr.addr    = j[IDX_W-1:0];
        wr.data    = ent;
        state_next = S_SH_CHK;
      end
      S_SPL_HI: begin
        alu_op  = ALU_SUB;
        alu_a   = ALU_W'(cur_len);
        alu_b   = size_q;
        wr.en   = 1'b1;
        wr.addr = idx_inc[IDX_W-1:0];
        wr.data = '{is_free: 1'b1, len: alu_y[LEN_W-1:0]};
        state_next = S_SPL_LO;
      end
      S_SPL_LO: begin
        wr.en   = 1'b1;
        wr.addr = idx[IDX_W-1:0];
        wr.data = '{is_free: 1'b0, len: size_q[LEN_W-1:0]};
        state_next = S_DONE;
      end
      S_MN_CHK: begin
        if (idx_inc < live) begin
          rd_addr    = idx_inc[IDX_W-1:0];
          state_next = S_MN_EV;
        end else begin
          state_next = S_MP;
        end
      end
      S_MN_EV: begin
        alu_a = ALU_W'(cur_len);
        alu_b = ALU_W'(ent.len);
        state_next = ent.is_free ? S_SH_CHK : S_MP;
      end
      S_MP: begin
        if (idx != '0 && prev_free) begin
          alu_a   = ALU_W'(prev_len);
          alu_b   = ALU_W'(cur_len);
          wr.en   = 1'b1;
          wr.addr = idx_dec[IDX_W-1:0];
          wr.data = '{is_free: 1'b1, len: alu_y[LEN_W-1:0]};
          state_next = S_SH_CHK;
        end else begin
          wr.en   = 1'b1;
          wr.addr = idx[IDX_W-1:0];
          wr.data = '{is_free: 1'b1, len: cur_len};
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live        <= CNT_W'(1);
      alloc_cnt   <= '0;
      alloc_bytes <= '0;
      res_status  <= ST_OK;
      res_addr    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q      <= req.cmd;
            size_q     <= size_rnd;
            thr_q      <= (SIZE_W + 1)'(size_rnd) + (SIZE_W + 1)'(HDR_BYTES + MIN_LEFTOVER);
            faddr_q    <= req.free_address;
            idx        <= '0;
            off_hdr    <= OFF_W'(HDR_BYTES);
            prev_free  <= 1'b0;
            res_addr   <= '0;
            res_status <= (req.cmd == CMD_FREE && req.free_address < ADDR_W'(NULL_LIMIT))
                          ? ST_NULL_ADDR : ST_OK;
          end
        end
        S_EV: begin
          if (cmd_q == CMD_ALLOC) begin
            if (fits_split && room) begin
              cur_len   <= ent.len;
              j         <= live;
              sh_up     <= 1'b1;
              ret_state <= S_SPL_HI;
            end else if (fits_exact) begin
              alloc_cnt   <= alloc_cnt + 1'b1;
              alloc_bytes <= alloc_bytes + size_q[LEN_W-1:0];
              res_addr    <= abs_addr;
            end else begin
              off_hdr <= alu_y[OFF_W-1:0];
              idx     <= idx_inc;
              if (walk_end) begin
                res_status <= ST_NO_FIT;
              end
            end
          end else begin
            if (addr_match) begin
              if (ent.is_free) begin
                res_status <= ST_ALREADY_FREE;
              end else begin
                cur_len     <= ent.len;
                alloc_cnt   <= alloc_cnt - 1'b1;
                alloc_bytes <= alloc_bytes - ent.len;
              end
            end else begin
              prev_len  <= ent.len;
              prev_free <= ent.is_free;
              off_hdr   <= alu_y[OFF_W-1:0];
              idx       <= idx_inc;
              if (walk_end) begin
                res_status <= ST_INVALID;
              end
            end
          end
        end
        S_SH_WR: begin
          j <= sh_up ? j_dec : j_inc;
        end
        S_SPL_LO: begin
          live        <= live + 1'b1;
          alloc_cnt   <= alloc_cnt + 1'b1;
          alloc_bytes <= alloc_bytes + size_q[LEN_W-1:0];
          res_addr    <= abs_addr;
        end
        S_MN_EV: begin
          if (ent.is_free) begin
            cur_len   <= alu_y[LEN_W-1:0];
            live      <= live - 1'b1;
            j         <= idx_inc;
            sh_up     <= 1'b0;
            ret_state <= S_MP;
          end
        end
        S_MP: begin
          if (idx != '0 && prev_free) begin
            live      <= live - 1'b1;
            j         <= idx;
            sh_up     <= 1'b0;
            ret_state <= S_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.alloc_address = res_addr;
  assign res.status        = res_status;
  assign res.used_count    = alloc_cnt;
  assign res.used_bytes    = alloc_bytes;
  assign res.segment_count = live;

  assert property (@(posedge clk) disable iff (rst)
    (alloc_cnt <= live) && (live != '0) && (live <= CNT_W'(MAX_SEGMENTS)))
    else $error("segment counters out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !wr.en)
    else $error("table written outside a request");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status != ST_OK) |-> (res_addr == '0))
    else $error("failed request carries an address");

  assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (CNT_W'(wr.addr) <= live))
    else $error("write beyond live segments");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SPL_LO) |=> (live == $past(live) + 1'b1))
    else $error("split did not add a segment");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ffha_pkg::*;

  localparam int     RX_HOLD_CYCLES = 600;   // long receiver hold-off, fills the block
  localparam int     IDLE_PAD       = 16;    // every request yields a result, so keep it short
  localparam int     SETTLE_CYCLES  = 6 * MAX_SEGMENTS + 16;
  localparam longint TIMEOUT_NS     = 40_000_000;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE
  } rx_pattern_e;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [71:0]         s_axis_tdata;   // [16:0] req_size, [64:17] free_address, zero pad
  logic                s_axis_tuser;   // cmd: 0 allocate, 1 free
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [87:0]         m_axis_tdata;   // [47:0] alloc_address, [50:48] status,
                                       // [57:51] used_count, [74:58] used_bytes,
                                       // [81:75] segment_count, zero pad

  // Shadow copy of the segment table, kept in step with accepted requests.
  logic [LEN_W-1:0]    seg_len_q  [MAX_SEGMENTS];
  logic                seg_free_q [MAX_SEGMENTS];
  int                  seg_live_q;
  int                  used_segs_q;
  int unsigned         used_total_q;
  logic [ADDR_W-1:0]   heap_base_q;

  result_t             pending_results[$];
  int                  error_count;

  // Sender and receiver pacing knobs, set by the test tasks.
  bit                  gap_en;
  int                  burst_left;
  rx_pattern_e         rx_mode;
  bit                  rx_hold_req;

  first_fit_heap_allocator_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // Allocator shadow
  // ------------------------------------------------------------------

  // Merge entry k into its successor when both are free; close the gap.
  function automatic void join_next(int k);
    int j;
    if (k + 1 >= seg_live_q) return;
    if (!seg_free_q[k] || !seg_free_q[k + 1]) return;
    seg_len_q[k] = seg_len_q[k] + seg_len_q[k + 1] + HDR_BYTES;
    for (j = k + 1; j + 1 < seg_live_q; j++) begin
      seg_len_q[j]  = seg_len_q[j + 1];
      seg_free_q[j] = seg_free_q[j + 1];
    end
    seg_live_q--;
  endfunction

  // First fit: split a roomy free segment, or take an exact one whole.
  // A segment that needs a split is passed over once the table is full.
  function automatic result_t grant_block(logic [LEN_W-1:0] req);
    int unsigned     want;
    longint unsigned off;
    int              i;
    int              j;
    bit              hit;
    result_t         r;
    r    = '0;
    off  = 0;
    hit  = 1'b0;
    want = (req == 0) ? 16 : req;
    want = (want + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    for (i = 0; i < seg_live_q; i++) begin
      if (seg_free_q[i]) begin
        if (seg_len_q[i] > want + HDR_BYTES + MIN_LEFTOVER) begin
          if (seg_live_q < MAX_SEGMENTS) begin
            for (j = seg_live_q; j > i + 1; j--) begin
              seg_len_q[j]  = seg_len_q[j - 1];
              seg_free_q[j] = seg_free_q[j - 1];
            end
            seg_len_q[i + 1]  = seg_len_q[i] - want - HDR_BYTES;
            seg_free_q[i + 1] = 1'b1;
            seg_live_q++;
            seg_len_q[i]  = want;
            seg_free_q[i] = 1'b0;
            hit = 1'b1;
            break;
          end
        end else if (seg_len_q[i] == want) begin
          seg_free_q[i] = 1'b0;
          hit = 1'b1;
          break;
        end
      end
      off += HDR_BYTES + seg_len_q[i];
    end
    if (hit) begin
      used_segs_q++;
      used_total_q += want;
      r.alloc_address = heap_base_q + off + HDR_BYTES;
      r.status        = ST_OK;
    end else begin
      r.status = ST_NO_FIT;
    end
    return r;
  endfunction

  // Release by data address, then coalesce with the successor and predecessor.
  function automatic status_e release_block(logic [ADDR_W-1:0] addr);
    longint unsigned   off;
    logic [ADDR_W-1:0] cand;
    int                i;
    if (addr < NULL_LIMIT) return ST_NULL_ADDR;
    off = 0;
    for (i = 0; i < seg_live_q; i++) begin
      cand = heap_base_q + off + HDR_BYTES;
      if (cand == addr) break;
      off += HDR_BYTES + seg_len_q[i];
    end
    if (i >= seg_live_q) return ST_INVALID;
    if (seg_free_q[i]) return ST_ALREADY_FREE;
    seg_free_q[i] = 1'b1;
    used_total_q -= seg_len_q[i];
    used_segs_q--;
    join_next(i);
    if (i > 0) join_next(i - 1);
    return ST_OK;
  endfunction

  function automatic logic [ADDR_W-1:0] segment_address(int idx);
    longint unsigned off;
    int              j;
    off = 0;
    for (j = 0; j < idx; j++) off += HDR_BYTES + seg_len_q[j];
    return heap_base_q + off + HDR_BYTES;
  endfunction

  // Random entry whose free mark matches, or -1 when there is none.
  function automatic int pick_segment(bit want_free);
    int cand[$];
    int i;
    for (i = 0; i < seg_live_q; i++)
      if (seg_free_q[i] == want_free) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_W-1:0];
  endfunction

  // ------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------

  // Offer one request in bursts with random gaps; predict on the transfer.
  task automatic send_request(cmd_e cmd, logic [LEN_W-1:0] size, logic [ADDR_W-1:0] addr);
    int      gap;
    result_t want_res;
    if (gap_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_axis_tdata  = {7'b0, addr, size};
    s_axis_tuser  = cmd;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == CMD_ALLOC) begin
      want_res = grant_block(size);
    end else begin
      want_res        = '0;
      want_res.status = release_block(addr);
    end
    want_res.used_count    = used_segs_q;
    want_res.used_bytes    = used_total_q;
    want_res.segment_count = seg_live_q;
    pending_results.push_back(want_res);
  endtask

  // Drop tvalid and hold until every outstanding result has come back.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  // Write heap_base only with the block idle; the shadow follows on the transfer.
  task automatic write_heap_base(logic [ADDR_W-1:0] base);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = base;
    do @(posedge clk); while (!cfg_ready);
    heap_base_q = base;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------

  // Pace tready; a hold request parks it low for a long stretch.
  initial begin : result_pacing
    int rx_tick;
    rx_tick       = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (rx_hold_req) begin
        rx_hold_req   = 1'b0;
        m_axis_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      case (rx_mode)
        RX_STEADY: m_axis_tready = 1'b1;
        RX_COIN:   m_axis_tready = $urandom_range(0, 1);
        default:   m_axis_tready = (rx_tick % 4 == 0);
      endcase
    end
  end

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : compare_results
    result_t want_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("alloc_address", want_res.alloc_address, m_axis_tdata[47:0]);
        check_field("status",        want_res.status,        m_axis_tdata[50:48]);
        check_field("used_count",    want_res.used_count,    m_axis_tdata[57:51]);
        check_field("used_bytes",    want_res.used_bytes,    m_axis_tdata[74:58]);
        check_field("segment_count", want_res.segment_count, m_axis_tdata[81:75]);
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Field extremes, every status code, merges, exact fit and address wrap.
  task automatic test_directed();
    gap_en  = 1'b0;
    rx_mode = RX_STEADY;
    // base 0 after reset: the first data address sits below the null limit
    send_request(CMD_FREE, '0, 48'd0);
    send_request(CMD_FREE, '1, NULL_LIMIT - 1);
    send_request(CMD_FREE, '0, segment_address(0));
    send_request(CMD_FREE, '0, NULL_LIMIT);
    send_request(CMD_ALLOC, 17'd0, '1);
    send_request(CMD_ALLOC, 17'd1, '0);
    send_request(CMD_ALLOC, 17'd17, '0);
    send_request(CMD_ALLOC, HEAP_BYTES, '0);
    send_request(CMD_ALLOC, '1, '0);
    write_heap_base(48'h0000_0001_0000);
    // free, free again, then coalesce back to one segment
    send_request(CMD_FREE, '0, segment_address(0));
    send_request(CMD_FREE, '0, segment_address(0));
    send_request(CMD_FREE, '0, segment_address(1));
    send_request(CMD_FREE, '0, segment_address(1));
    send_request(CMD_FREE, '0, segment_address(0) + 1);
    // whole heap as one exact fit, then nothing left
    send_request(CMD_ALLOC, HEAP_BYTES - HDR_BYTES, '0);
    send_request(CMD_ALLOC, 17'd0, '0);
    send_request(CMD_FREE, '0, segment_address(0));
    // top of the address space: data addresses wrap past zero
    write_heap_base('1);
    send_request(CMD_ALLOC, 17'd16, '0);
    send_request(CMD_FREE, '0, segment_address(0));
    write_heap_base(48'hFFFF_FFFF_F800);
    send_request(CMD_ALLOC, 17'd2000, '0);
    send_request(CMD_ALLOC, 17'd100, '0);
    send_request(CMD_FREE, '0, segment_address(3));
    send_request(CMD_FREE, '0, segment_address(2));
  endtask

  // Fill the table to its limit, then check skipping of splits and late exact fits.
  task automatic test_table_full();
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  hole_len;
    int                k;
    int                hole;
    int                round;
    gap_en  = 1'b1;
    rx_mode = RX_COIN;
    base = rand48();
    base[47:46] = 2'b10;   // keep every data address clear of the null limit
    write_heap_base(base);
    for (round = 0; round < 3; round++) begin
      k = pick_segment(1'b0);
      while (k >= 0) begin
        send_request(CMD_FREE, $urandom, segment_address(k));
        k = pick_segment(1'b0);
      end
      send_request(CMD_ALLOC, $urandom_range(4081, 4096), rand48());
      while (seg_live_q < MAX_SEGMENTS) begin
        if (round == 0 && seg_live_q == 20) rx_hold_req = 1'b1;
        send_request(CMD_ALLOC, $urandom_range(0, 128), rand48());
      end
      // only the tail remainder is free, and it would need a split
      send_request(CMD_ALLOC, $urandom_range(1, 512), rand48());
      send_request(CMD_FREE, $urandom, segment_address(0));
      hole     = $urandom_range(5, MAX_SEGMENTS - 5);
      hole_len = seg_len_q[hole];
      send_request(CMD_FREE, $urandom, segment_address(hole));
      // the big free head is skipped; the hole further on fits exactly
      send_request(CMD_ALLOC, hole_len, rand48());
      repeat (6) begin
        k = pick_segment(1'b0);
        if ($urandom_range(0, 1) && k >= 0)
          send_request(CMD_FREE, $urandom, segment_address(k));
        else
          send_request(CMD_ALLOC, $urandom_range(0, 256), rand48());
      end
    end
  endtask

  // Mixed traffic: mostly well-formed alloc/free pairs, some bad frees.
  task automatic test_random();
    logic [LEN_W-1:0]  size;
    logic [ADDR_W-1:0] addr;
    int                phase;
    int                n;
    int                pick;
    int                k;
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       write_heap_base('0);
        1:       write_heap_base('1);
        default: write_heap_base(rand48());
      endcase
      // phases 0, 3 and 6 run with no idling on either side
      gap_en  = (phase % 3 != 0);
      rx_mode = rx_pattern_e'(phase % 3);
      for (n = 0; n < 210; n++) begin
        if (phase == 5 && n == 50) rx_hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        addr = rand48();
        size = $urandom;
        if (pick < 45) begin
          k = $urandom_range(0, 99);
          if (k < 70)      size = $urandom_range(0, 256);
          else if (k < 90) size = $urandom_range(257, 4096);
          else if (k < 98) size = $urandom_range(4097, HEAP_BYTES);
          send_request(CMD_ALLOC, size, addr);
        end else if (pick < 85) begin
          k = pick_segment(1'b0);
          if (k >= 0) addr = segment_address(k);
          send_request(CMD_FREE, size, addr);
        end else begin
          case ($urandom_range(0, 3))
            0: begin
              k = pick_segment(1'b1);
              if (k >= 0) addr = segment_address(k);
            end
            1: addr = $urandom_range(0, NULL_LIMIT - 1);
            2: ;
            default: begin
              k = $urandom_range(0, seg_live_q - 1);
              addr = segment_address(k) + $urandom_range(1, HDR_BYTES);
            end
          endcase
          send_request(CMD_FREE, size, addr);
        end
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin : run_tests
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ALLOC;
    error_count   = 0;
    gap_en        = 1'b0;
    burst_left    = 0;
    rx_mode       = RX_STEADY;
    rx_hold_req   = 1'b0;
    // shadow starts as one free segment spanning the heap
    foreach (seg_len_q[i]) begin
      seg_len_q[i]  = '0;
      seg_free_q[i] = 1'b0;
    end
    seg_len_q[0]  = HEAP_BYTES - HDR_BYTES;
    seg_free_q[0] = 1'b1;
    seg_live_q    = 1;
    used_segs_q   = 0;
    used_total_q  = 0;
    heap_base_q   = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_table_full();
    test_random();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/ffha_pkg.sv
design/ffha_mem.sv
design/ffha_alu.sv
design/ffha_core.sv
design/first_fit_heap_allocator_top.sv
tb/sv/testbench.sv
